/* rtl/core/pnp_pkg.sv */
// Package for the principal name parser.
// Holds character codes, the field-count default, the result and state types and the escape and realm-check functions.
// No dependencies.
package pnp_pkg;

    localparam int MAX_FIELDS_DEF = 16;

    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 4;
    localparam int TDATA_W = 16;
    localparam int TUSER_W = 2;

    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;

    typedef struct packed {
        logic [CHAR_W-1:0]  byte_out;
        logic               byte_valid;
        logic [INDEX_W-1:0] field_index;
        logic               in_realm;
        logic               field_end;
        logic               malformed;
        logic               name_done;
    } pnp_result_t;

    typedef struct packed {
        logic               escape_pending;
        logic               realm_seen;
        logic               error_seen;
        logic [INDEX_W-1:0] field_counter;
    } pnp_state_t;

    function automatic logic [CHAR_W-1:0] decode_escaped(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        case (c)
            CH_N:    d = CH_LF;
            CH_T:    d = CH_TAB;
            CH_B:    d = CH_BS;
            CH_ZERO: d = CH_NUL;
            default: d = c;
        endcase
        return d;
    endfunction

    function automatic logic realm_forbidden(input logic [CHAR_W-1:0] c);
        return (c == CH_COLON) || (c == CH_SLASH) || (c == CH_NUL);
    endfunction

endpackage

/* rtl/core/pnp_step.sv */
// Per-character parse step: parser state registers and the result logic.
// Depends on pnp_pkg.
module pnp_step #(
    parameter int MAX_FIELDS = pnp_pkg::MAX_FIELDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         beat_in,
    input  logic [pnp_pkg::CHAR_W-1:0]   char_in,
    input  logic                         last_char,
    output pnp_pkg::pnp_result_t         result
);

    localparam logic [pnp_pkg::INDEX_W-1:0] FIELD_TOP =
        pnp_pkg::INDEX_W'((MAX_FIELDS - 1 < 15) ? (MAX_FIELDS - 1) : 15);

    pnp_pkg::pnp_state_t state_reg;
    pnp_pkg::pnp_state_t state_next;

    logic [pnp_pkg::CHAR_W-1:0] dec;
    logic                       bad;
    logic                       valid;
    logic                       fend;

    always_comb
    begin
        state_next = state_reg;
        bad        = 1'b0;
        valid      = 1'b0;
        fend       = 1'b0;
        dec        = pnp_pkg::decode_escaped(char_in);

        if (state_reg.escape_pending)
        begin
            state_next.escape_pending = 1'b0;
            if (state_reg.realm_seen && pnp_pkg::realm_forbidden(dec))
                bad = 1'b1;
            else
                valid = 1'b1;
        end
        else if (char_in == pnp_pkg::CH_BSLASH)
        begin
            if (last_char)
                bad = 1'b1;
            else
                state_next.escape_pending = 1'b1;
        end
        else if (char_in == pnp_pkg::CH_SLASH || char_in == pnp_pkg::CH_AT)
        begin
            if (state_reg.realm_seen)
                bad = 1'b1;
            else
            begin
                fend = 1'b1;
                if (state_reg.field_counter < FIELD_TOP)
                    state_next.field_counter = state_reg.field_counter + 1'b1;
                if (char_in == pnp_pkg::CH_AT)
                    state_next.realm_seen = 1'b1;
            end
        end
        else
        begin
            dec = char_in;
            if (state_reg.realm_seen &&
                (char_in == pnp_pkg::CH_COLON || char_in == pnp_pkg::CH_NUL))
                bad = 1'b1;
            else
                valid = 1'b1;
        end

        if (bad)
            state_next.error_seen = 1'b1;

        result.byte_out    = valid ? dec : pnp_pkg::CH_NUL;
        result.byte_valid  = valid;
        result.field_index = state_reg.field_counter;
        result.in_realm    = state_reg.realm_seen;
        result.field_end   = fend || last_char;
        result.malformed   = state_next.error_seen;
        result.name_done   = last_char;

        // end of name: back to the start state
        if (last_char)
            state_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (beat_in)
            state_reg <= state_next;
    end

endmodule

/* rtl/core/pnp_outbuf.sv */
// Two-entry result register with skid stage for the output stream.
// Depends on pnp_pkg.
module pnp_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pnp_pkg::pnp_result_t push_data,
    output logic                 ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pnp_pkg::pnp_result_t out_data
);

    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    pnp_pkg::pnp_result_t main_data_reg;
    pnp_pkg::pnp_result_t skid_data_reg;
    logic                 pop;

    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

endmodule

/* rtl/core/principal_name_parser.sv */
// Top level of the principal name parser: stream ports, parse step and output buffer.
// Depends on pnp_pkg, pnp_step and pnp_outbuf.
//
// One character of a principal name enters per beat, tlast on the final character,
// and one result beat leaves for each. The parse step is combinational and each
// result is registered in the output buffer. Throughput is one character per cycle
// while m_tready is high; the two-entry output buffer keeps input open for one more
// beat while a result waits on m_tready, then s_tready drops until the skid drains.
// The field index saturates at min(MAX_FIELDS-1, 15); parse state returns to its
// start after each tlast beat.
module principal_name_parser #(
    parameter int MAX_FIELDS = pnp_pkg::MAX_FIELDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pnp_pkg::CHAR_W-1:0]   s_tdata,  // [7:0] char_in
    input  logic                         s_tlast,  // last_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] byte_out, [11:8] field_index, [12] field_end, [13] malformed, [15:14] zero
    output logic [pnp_pkg::TDATA_W-1:0]  m_tdata,
    output logic [pnp_pkg::TUSER_W-1:0]  m_tuser,  // [0] byte_valid, [1] in_realm
    output logic                         m_tlast   // name_done
);

    logic                 beat_in;
    pnp_pkg::pnp_result_t step_result;
    pnp_pkg::pnp_result_t out_result;

    assign beat_in = s_tvalid && s_tready;

    pnp_step #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_in   (beat_in),
        .char_in   (s_tdata),
        .last_char (s_tlast),
        .result    (step_result)
    );

    pnp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (beat_in),
        .push_data (step_result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {2'b00, out_result.malformed, out_result.field_end,
                      out_result.field_index, out_result.byte_out};
    assign m_tuser = {out_result.in_realm, out_result.byte_valid};
    assign m_tlast = out_result.name_done;

endmodule

/* rtl/core/pnp_checker.sv */
// Port-level checker for principal_name_parser, bound to the top level.
// Depends on pnp_pkg.
module pnp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pnp_pkg::TDATA_W-1:0] m_tdata,
    input logic [pnp_pkg::TUSER_W-1:0] m_tuser,
    input logic                        m_tlast
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == pnp_pkg::CH_NUL)
        else $error("non-text beat carries a byte");

    a_realm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && m_tuser[1] |->
            m_tdata[7:0] != pnp_pkg::CH_COLON && m_tdata[7:0] != pnp_pkg::CH_SLASH
            && m_tdata[7:0] != pnp_pkg::CH_NUL)
        else $error("forbidden byte reported as realm text");

    a_last_ends_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[12])
        else $error("last beat without field end");

    a_malformed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[13] && !m_tlast |=> !m_tvalid || m_tdata[13])
        else $error("malformed flag dropped inside a name");

endmodule

bind principal_name_parser pnp_checker u_pnp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* test/principal_name_checker.sv */
`timescale 1ns / 1ps
// Checker for principal_name_parser: watches the character and result streams,
// predicts each result beat from the accepted characters and compares it field by field.
// Depends on pnp_pkg.
module principal_name_checker import pnp_pkg::*; #(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [TUSER_W-1:0] m_tuser,
    input  logic               m_tlast,
    output int                 fail_count,
    output int                 pending,
    output int                 names_seen,
    output int                 realm_names,
    output int                 bad_names,
    output int                 top_index
);

    localparam int FIELD_TOP = (MAX_FIELDS - 1 < 15) ? MAX_FIELDS - 1 : 15;

    logic               esc_pending;
    logic               realm_open;
    logic               error_flag;
    logic [INDEX_W-1:0] field_cnt;
    pnp_result_t        expected_results[$];

    function automatic logic [CHAR_W-1:0] unescape(input logic [CHAR_W-1:0] c);
        if (c == CH_N)
            return CH_LF;
        if (c == CH_T)
            return CH_TAB;
        if (c == CH_B)
            return CH_BS;
        if (c == CH_ZERO)
            return CH_NUL;
        return c;
    endfunction

    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic lst,
                              output pnp_result_t r);
        logic [CHAR_W-1:0] d;
        logic              bad;
        r = '0;
        bad = 1'b0;
        r.field_index = field_cnt;
        r.in_realm = realm_open;
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            d = unescape(c);
            if (realm_open && (d == CH_COLON || d == CH_SLASH || d == CH_NUL))
                bad = 1'b1;
            else
            begin
                r.byte_valid = 1'b1;
                r.byte_out = d;
            end
        end
        else if (c == CH_BSLASH)
        begin
            if (lst)
                bad = 1'b1;
            else
                esc_pending = 1'b1;
        end
        else if (c == CH_SLASH || c == CH_AT)
        begin
            if (realm_open)
                bad = 1'b1;
            else
            begin
                r.field_end = 1'b1;
                if (field_cnt < FIELD_TOP)
                    field_cnt = field_cnt + 1'b1;
                if (c == CH_AT)
                    realm_open = 1'b1;
            end
        end
        else if (realm_open && (c == CH_COLON || c == CH_NUL))
        begin
            bad = 1'b1;
        end
        else
        begin
            r.byte_valid = 1'b1;
            r.byte_out = c;
        end
        if (bad)
            error_flag = 1'b1;
        if (lst)
            r.field_end = 1'b1;
        r.malformed = error_flag;
        r.name_done = lst;
        if (int'(r.field_index) > top_index)
            top_index = int'(r.field_index);
        if (lst)
        begin
            names_seen++;
            if (realm_open)
                realm_names++;
            if (error_flag)
                bad_names++;
            esc_pending = 1'b0;
            realm_open = 1'b0;
            error_flag = 1'b0;
            field_cnt = '0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pnp_result_t want;
        if (!rst_n)
        begin
            esc_pending = 1'b0;
            realm_open = 1'b0;
            error_flag = 1'b0;
            field_cnt = '0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            names_seen = 0;
            realm_names = 0;
            bad_names = 0;
            top_index = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_char(s_tdata, s_tlast, want);
                expected_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no character outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("byte_out", int'(want.byte_out), int'(m_tdata[7:0]));
                    check_field("byte_valid", int'(want.byte_valid), int'(m_tuser[0]));
                    check_field("field_index", int'(want.field_index), int'(m_tdata[11:8]));
                    check_field("in_realm", int'(want.in_realm), int'(m_tuser[1]));
                    check_field("field_end", int'(want.field_end), int'(m_tdata[12]));
                    check_field("malformed", int'(want.malformed), int'(m_tdata[13]));
                    check_field("name_done", int'(want.name_done), int'(m_tlast));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for principal_name_parser: clock, reset, character stimulus and verdict.
// Depends on pnp_pkg, principal_name_parser and principal_name_checker.
module tb_top;
    import pnp_pkg::*;

    localparam int CHAR_BUDGET = 1850;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic               m_tlast;

    int fail_count;
    int pending;
    int names_seen;
    int realm_names;
    int bad_names;
    int top_index;

    int                chars_sent;
    int                burst_left;
    int                ready_mode;
    int                mode_left;
    bit                has_realm;
    logic [CHAR_W-1:0] name_buf[$];

    principal_name_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    principal_name_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .names_seen  (names_seen),
        .realm_names (realm_names),
        .bad_names   (bad_names),
        .top_index   (top_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: m_tready follows a stall pattern that switches between modes
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic lst);
        pace();
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_name();
        foreach (name_buf[i])
            send_char(name_buf[i], i == name_buf.size() - 1);
        name_buf.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] plain_char(input bit realm);
        logic [CHAR_W-1:0] c;
        do
        begin
            if ($urandom_range(0, 2) != 0)
                c = CHAR_W'($urandom_range(8'h21, 8'h7E));
            else
                c = CHAR_W'($urandom_range(0, 255));
        end
        while (c == CH_SLASH || c == CH_AT || c == CH_BSLASH ||
               (realm && (c == CH_COLON || c == CH_NUL)));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] escaped_char(input bit realm);
        logic [CHAR_W-1:0] c;
        do
        begin
            case ($urandom_range(0, 7))
                0: c = CH_N;
                1: c = CH_T;
                2: c = CH_B;
                3: c = CH_ZERO;
                4: c = CH_SLASH;
                5: c = CH_AT;
                6: c = CH_BSLASH;
                default: c = CHAR_W'($urandom_range(0, 255));
            endcase
        end
        while (realm && (c == CH_ZERO || c == CH_COLON || c == CH_SLASH || c == CH_NUL));
        return c;
    endfunction

    task automatic add_text(input bit realm, input int len);
        repeat (len)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                name_buf.push_back(CH_BSLASH);
                name_buf.push_back(escaped_char(realm));
            end
            else
                name_buf.push_back(plain_char(realm));
        end
    endtask

    task automatic build_clean_name();
        int comps;
        comps = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
        for (int i = 0; i < comps; i++)
        begin
            add_text(1'b0, $urandom_range(0, 5));
            if (i < comps - 1)
                name_buf.push_back(CH_SLASH);
        end
        has_realm = ($urandom_range(0, 9) < 7);
        if (has_realm)
        begin
            name_buf.push_back(CH_AT);
            add_text(1'b1, $urandom_range(0, 6));
        end
        if (name_buf.size() == 0)
            name_buf.push_back(plain_char(1'b0));
    endtask

    task automatic build_broken_name();
        build_clean_name();
        if ($urandom_range(0, 4) == 0)
            name_buf.push_back(CH_BSLASH);
        else
        begin
            if (!has_realm)
                name_buf.push_back(CH_AT);
            name_buf.push_back(plain_char(1'b1));
            case ($urandom_range(0, 5))
                0: name_buf.push_back(CH_AT);
                1: name_buf.push_back(CH_SLASH);
                2: name_buf.push_back(CH_COLON);
                3: name_buf.push_back(CH_NUL);
                4:
                begin
                    name_buf.push_back(CH_BSLASH);
                    name_buf.push_back(CH_ZERO);
                end
                default:
                begin
                    name_buf.push_back(CH_BSLASH);
                    name_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_COLON);
                end
            endcase
            add_text(1'b1, $urandom_range(0, 4));
        end
    endtask

    task automatic build_noise_name();
        repeat ($urandom_range(1, 10))
        begin
            if ($urandom_range(0, 2) == 0)
                case ($urandom_range(0, 6))
                    0: name_buf.push_back(CH_SLASH);
                    1: name_buf.push_back(CH_AT);
                    2: name_buf.push_back(CH_COLON);
                    3: name_buf.push_back(CH_BSLASH);
                    4: name_buf.push_back(CH_NUL);
                    5: name_buf.push_back(CH_N);
                    default: name_buf.push_back(CH_ZERO);
                endcase
            else
                name_buf.push_back(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        chars_sent = 0;
        burst_left = 0;
        mode_left = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // raw NUL and 0xFF outside the realm, all escapes, slash as last character
        name_buf = '{CH_NUL, CH_BSLASH, CH_N, CH_BSLASH, CH_T, CH_BSLASH, CH_B,
                     CH_BSLASH, CH_ZERO, CH_BSLASH, CH_SLASH, 8'hFF, CH_SLASH};
        send_name();
        // realm faults, sticky error, trailing backslash
        name_buf = '{8'h61, CH_AT, CH_COLON, CH_BSLASH, CH_SLASH, CH_BSLASH, CH_ZERO,
                     CH_NUL, CH_SLASH, CH_AT, CH_BSLASH};
        send_name();
        // at-sign as last character opens an empty realm
        name_buf = '{8'h78, CH_AT};
        send_name();
        drain();

        while (chars_sent < CHAR_BUDGET)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: build_broken_name();
                3, 4, 5: build_noise_name();
                default: build_clean_name();
            endcase
            send_name();
            if ($urandom_range(0, 29) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d character beats in %0d names: %0d with a realm, %0d malformed.",
                 chars_sent, names_seen, realm_names, bad_names);
        $display("Highest field index reached: %0d.", top_index);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
